// ===== rtl/semaphore_table_with_wait_queues_macros.svh =====
// Assertion macros for the semaphore table.
// Used by semaphore_table_with_wait_queues.sv; expects signals clock and reset in scope.
`ifndef SEMAPHORE_TABLE_WITH_WAIT_QUEUES_MACROS_SVH
`define SEMAPHORE_TABLE_WITH_WAIT_QUEUES_MACROS_SVH

// same-cycle implication, checked outside reset
`define SEMTQ_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("semaphore table assertion failed");

// next-cycle implication, checked outside reset
`define SEMTQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("semaphore table assertion failed");

`endif

// ===== rtl/semtq_pkg.sv =====
// Types and codes for the semaphore table with wait queues.
// No dependencies; used by semaphore_table_with_wait_queues.sv.
package semtq_pkg;

   typedef enum logic [1:0] {
      KIND_CREATE  = 2'd0,
      KIND_DESTROY = 2'd1,
      KIND_WAIT    = 2'd2,
      KIND_SIGNAL  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_ERR  = 2'd1,
      ST_SUSP = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_META_WAIT,
      S_EXEC,
      S_WAKE,
      S_DRAIN_RD,
      S_REPLY
   } state_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  sem_index;
      logic [15:0] init_value;
      logic [14:0] requester;
   } req_type;

   typedef struct packed {
      logic        is_wake;
      logic [14:0] target_process;
      status_type  status;
      logic [7:0]  created_index;
      logic        last;
   } rsp_type;

endpackage

// ===== rtl/semaphore_table_with_wait_queues.sv =====
// Counting semaphore table with a FIFO wait queue per semaphore.
// Depends on semtq_pkg and semaphore_table_with_wait_queues_macros.svh.
//
//   channel | ports                         | moves
//   --------+-------------------------------+------------------------------
//   request | req_valid, req_stall, req_item| one operation item
//   result  | rsp_valid, rsp_stall, rsp_item| wake notices, then the reply
//
// A new request is taken only in idle, once the reply to the last one has gone out.
// Create probes the slots from the lowest up, one slot per cycle, and takes the lowest
// free slot (an error reply when all are in use); destroy and V with waiter make one
// ring read per wake.
// Reset clears the slot flags and the sequencer and holds req_stall high.
// rsp_stall holds the output register, and the sequencer waits for it to free up.
`include "semaphore_table_with_wait_queues_macros.svh"

module semaphore_table_with_wait_queues #(
   parameter int NUM_SEMAPHORES = 64,
   parameter int MAX_WAITERS    = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  semtq_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output semtq_pkg::rsp_type rsp_item
);

   localparam int SW  = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
   localparam int WW  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
   localparam int CW  = $clog2(MAX_WAITERS + 1);
   localparam int RD  = NUM_SEMAPHORES * MAX_WAITERS;
   localparam int RAW = (RD > 1) ? $clog2(RD) : 1;
   localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SEMAPHORES - 1);
   localparam logic [CW-1:0] MAX_WC    = CW'(MAX_WAITERS);
   localparam logic [WW:0]   MAX_POS   = (WW+1)'(MAX_WAITERS);
   localparam logic [WW-1:0] LAST_POS  = WW'(MAX_WAITERS - 1);
   localparam logic [8:0]    NUM_LIM   = 9'(NUM_SEMAPHORES);

   typedef struct packed {
      logic [15:0]   count;
      logic [CW-1:0] waiters;
      logic [WW-1:0] head;
   } meta_type;

   meta_type    meta_mem [NUM_SEMAPHORES];
   logic [14:0] ring_mem [RD];

   semtq_pkg::state_type  state_ff, state_in;
   semtq_pkg::req_type    req_ff, req_in;
   semtq_pkg::status_type rep_status_ff, rep_status_in;
   semtq_pkg::rsp_type    rsp_ff, rsp_in;
   logic [SW-1:0]         slot_ff, slot_in;
   logic [CW-1:0]         k_ff, k_in, k_next;
   logic [7:0]            rep_created_ff, rep_created_in;
   logic [NUM_SEMAPHORES-1:0] in_use_ff, in_use_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   meta_type              meta_q_ff, meta_wdata;
   logic [14:0]           ring_q_ff;

   logic          use_set, use_clr, meta_we, ring_we, ring_rd_en;
   logic          emit_wake, emit_reply, out_free;
   logic [CW-1:0] off;
   logic [WW:0]   pos_sum, pos_wrap;
   logic [WW-1:0] pos, head_next;
   logic [RAW-1:0] ring_addr;

   // shared ring position unit: (head + offset) mod MAX_WAITERS, then slot base
   assign off       = (state_ff == semtq_pkg::S_EXEC && req_ff.kind == semtq_pkg::KIND_WAIT)
                      ? meta_q_ff.waiters : k_ff;
   assign pos_sum   = {1'b0, meta_q_ff.head} + {1'b0, off[WW-1:0]};
   assign pos_wrap  = (pos_sum >= MAX_POS) ? pos_sum - MAX_POS : pos_sum;
   assign pos       = pos_wrap[WW-1:0];
   assign head_next = (pos == LAST_POS) ? '0 : pos + WW'(1);
   assign ring_addr = RAW'(slot_ff * MAX_WAITERS) + RAW'(pos);
   assign k_next    = k_ff + CW'(1);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || (state_ff != semtq_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      slot_in        = slot_ff;
      k_in           = k_ff;
      rep_status_in  = rep_status_ff;
      rep_created_in = rep_created_ff;
      use_set        = 1'b0;
      use_clr        = 1'b0;
      meta_we        = 1'b0;
      meta_wdata     = meta_q_ff;
      ring_we        = 1'b0;
      ring_rd_en     = 1'b0;
      emit_wake      = 1'b0;
      emit_reply     = 1'b0;

      unique case (state_ff)
         semtq_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in         = req_item;
               k_in           = '0;
               rep_created_in = '0;
               if (req_item.kind == semtq_pkg::KIND_CREATE) begin
                  slot_in  = '0;
                  state_in = semtq_pkg::S_SCAN;
               end else if ({1'b0, req_item.sem_index} >= NUM_LIM) begin
                  rep_status_in = semtq_pkg::ST_ERR;
                  state_in      = semtq_pkg::S_REPLY;
               end else begin
                  slot_in  = SW'(req_item.sem_index);
                  state_in = semtq_pkg::S_META_WAIT;
               end
            end
         end
         semtq_pkg::S_SCAN: begin
            if (!in_use_ff[slot_ff]) begin
               use_set        = 1'b1;
               meta_we        = 1'b1;
               meta_wdata     = '{count: req_ff.init_value, waiters: '0, head: '0};
               rep_status_in  = semtq_pkg::ST_OK;
               rep_created_in = 8'(slot_ff);
               state_in       = semtq_pkg::S_REPLY;
            end else if (slot_ff == LAST_SLOT) begin
               rep_status_in = semtq_pkg::ST_ERR;
               state_in      = semtq_pkg::S_REPLY;
            end else begin
               slot_in = slot_ff + SW'(1);
            end
         end
         semtq_pkg::S_META_WAIT: begin
            state_in = semtq_pkg::S_EXEC;
         end
         semtq_pkg::S_EXEC: begin
            ring_rd_en = 1'b1;
            state_in   = semtq_pkg::S_REPLY;
            if (!in_use_ff[slot_ff]) begin
               rep_status_in = semtq_pkg::ST_ERR;
            end else begin
               unique case (req_ff.kind)
                  semtq_pkg::KIND_DESTROY: begin
                     use_clr       = 1'b1;
                     rep_status_in = semtq_pkg::ST_OK;
                     if (meta_q_ff.waiters != '0) state_in = semtq_pkg::S_WAKE;
                  end
                  semtq_pkg::KIND_WAIT: begin
                     if (meta_q_ff.count != '0) begin
                        meta_we          = 1'b1;
                        meta_wdata.count = meta_q_ff.count - 16'd1;
                        rep_status_in    = semtq_pkg::ST_OK;
                     end else if (meta_q_ff.waiters >= MAX_WC) begin
                        rep_status_in = semtq_pkg::ST_ERR;
                     end else begin
                        ring_we            = 1'b1;
                        meta_we            = 1'b1;
                        meta_wdata.waiters = meta_q_ff.waiters + CW'(1);
                        rep_status_in      = semtq_pkg::ST_SUSP;
                     end
                  end
                  semtq_pkg::KIND_SIGNAL: begin
                     meta_we       = 1'b1;
                     rep_status_in = semtq_pkg::ST_OK;
                     if (meta_q_ff.waiters == '0) begin
                        if (meta_q_ff.count != 16'hFFFF)
                           meta_wdata.count = meta_q_ff.count + 16'd1;
                     end else begin
                        meta_wdata.head    = head_next;
                        meta_wdata.waiters = meta_q_ff.waiters - CW'(1);
                        state_in           = semtq_pkg::S_WAKE;
                     end
                  end
                  semtq_pkg::KIND_CREATE: begin
                     rep_status_in = semtq_pkg::ST_ERR;
                  end
               endcase
            end
         end
         semtq_pkg::S_WAKE: begin
            if (out_free) begin
               emit_wake = 1'b1;
               if (req_ff.kind == semtq_pkg::KIND_SIGNAL) begin
                  state_in = semtq_pkg::S_REPLY;
               end else begin
                  k_in     = k_next;
                  state_in = (k_next == meta_q_ff.waiters) ? semtq_pkg::S_REPLY
                                                           : semtq_pkg::S_DRAIN_RD;
               end
            end
         end
         semtq_pkg::S_DRAIN_RD: begin
            ring_rd_en = 1'b1;
            state_in   = semtq_pkg::S_WAKE;
         end
         semtq_pkg::S_REPLY: begin
            if (out_free) begin
               emit_reply = 1'b1;
               state_in   = semtq_pkg::S_IDLE;
            end
         end
         default: state_in = semtq_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      in_use_in = in_use_ff;
      if (use_set) in_use_in[slot_ff] = 1'b1;
      if (use_clr) in_use_in[slot_ff] = 1'b0;

      rsp_in = rsp_ff;
      if (emit_wake) begin
         rsp_in = '{is_wake: 1'b1, target_process: ring_q_ff, status: semtq_pkg::ST_OK,
                    created_index: 8'd0, last: 1'b0};
      end else if (emit_reply) begin
         rsp_in = '{is_wake: 1'b0, target_process: req_ff.requester,
                    status: rep_status_ff, created_index: rep_created_ff, last: 1'b1};
      end

      if (emit_wake || emit_reply) rsp_valid_in = 1'b1;
      else if (!rsp_stall)         rsp_valid_in = 1'b0;
      else                         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= semtq_pkg::S_IDLE;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      slot_ff        <= slot_in;
      k_ff           <= k_in;
      rep_status_ff  <= rep_status_in;
      rep_created_ff <= rep_created_in;
      rsp_ff         <= rsp_in;
   end

   // per-slot count, queue length and head
   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[slot_ff] <= meta_wdata;
      meta_q_ff <= meta_mem[slot_ff];
   end

   // waiter ring, MAX_WAITERS entries per slot
   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[ring_addr] <= req_ff.requester;
      if (ring_rd_en) ring_q_ff <= ring_mem[ring_addr];
   end

   `SEMTQ_ASSERT_IMPLY(a_last_only_on_reply, rsp_valid, rsp_item.is_wake != rsp_item.last)
   `SEMTQ_ASSERT_IMPLY(a_created_only_ok_reply, rsp_valid && rsp_item.created_index != 8'd0,
                       rsp_item.status == semtq_pkg::ST_OK && !rsp_item.is_wake)
   `SEMTQ_ASSERT_NEXT(a_accept_leaves_idle, req_valid && !req_stall,
                      state_ff != semtq_pkg::S_IDLE)

endmodule

// ===== dv/semaphore_table_with_wait_queues_test.sv =====
// Self-checking testbench for semaphore_table_with_wait_queues: a scoreboard mirrors the
// semaphore table and its wait rings, and every accepted response item is checked in order.
// Depends on semtq_pkg and the semaphore_table_with_wait_queues RTL.
module semaphore_table_with_wait_queues_test;

   localparam int NUM_SEM  = 64;
   localparam int MAX_WAIT = 32;
   localparam int CYCLE_LIMIT = 1000000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   semtq_pkg::req_type req_item;
   logic               rsp_valid;
   logic               rsp_stall;
   semtq_pkg::rsp_type rsp_item;

   semaphore_table_with_wait_queues #(
      .NUM_SEMAPHORES(NUM_SEM),
      .MAX_WAITERS(MAX_WAIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item)
   );

   // mirror of the semaphore table
   bit          sem_live [NUM_SEM];
   logic [15:0] sem_count [NUM_SEM];
   int          sem_waiters [NUM_SEM];
   int          sem_head [NUM_SEM];
   logic [14:0] sem_ring [NUM_SEM][MAX_WAIT];

   semtq_pkg::rsp_type due_notices [$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   int      burst_left = 0;
   int      stall_mode = 0;
   int      stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic void post(logic wake, logic [14:0] who, semtq_pkg::status_type st,
                                logic [7:0] made, logic fin);
      semtq_pkg::rsp_type n;
      n.is_wake        = wake;
      n.target_process = who;
      n.status         = st;
      n.created_index  = made;
      n.last           = fin;
      due_notices.push_back(n);
   endfunction

   // Applies one accepted request to the mirror and queues the items it owes.
   function automatic void run_semaphore_op(semtq_pkg::req_type r);
      int s;
      int k;
      int slot;
      int id;
      id = r.sem_index;
      if (r.kind == semtq_pkg::KIND_CREATE) begin
         slot = -1;
         for (s = NUM_SEM - 1; s >= 0; s--)
            if (!sem_live[s]) slot = s;
         if (slot < 0) begin
            post(1'b0, r.requester, semtq_pkg::ST_ERR, 8'd0, 1'b1);
         end else begin
            sem_live[slot]    = 1'b1;
            sem_count[slot]   = r.init_value;
            sem_waiters[slot] = 0;
            sem_head[slot]    = 0;
            post(1'b0, r.requester, semtq_pkg::ST_OK, 8'(slot), 1'b1);
         end
         return;
      end
      if (id >= NUM_SEM || !sem_live[id]) begin
         post(1'b0, r.requester, semtq_pkg::ST_ERR, 8'd0, 1'b1);
         return;
      end
      case (r.kind)
         semtq_pkg::KIND_DESTROY: begin
            sem_live[id] = 1'b0;
            for (k = 0; k < sem_waiters[id]; k++)
               post(1'b1, sem_ring[id][(sem_head[id] + k) % MAX_WAIT], semtq_pkg::ST_OK,
                    8'd0, 1'b0);
            sem_waiters[id] = 0;
            sem_head[id]    = 0;
            post(1'b0, r.requester, semtq_pkg::ST_OK, 8'd0, 1'b1);
         end
         semtq_pkg::KIND_WAIT: begin
            if (sem_count[id] != 16'd0) begin
               sem_count[id] = sem_count[id] - 16'd1;
               post(1'b0, r.requester, semtq_pkg::ST_OK, 8'd0, 1'b1);
            end else if (sem_waiters[id] >= MAX_WAIT) begin
               post(1'b0, r.requester, semtq_pkg::ST_ERR, 8'd0, 1'b1);
            end else begin
               sem_ring[id][(sem_head[id] + sem_waiters[id]) % MAX_WAIT] = r.requester;
               sem_waiters[id]++;
               post(1'b0, r.requester, semtq_pkg::ST_SUSP, 8'd0, 1'b1);
            end
         end
         default: begin
            if (sem_waiters[id] == 0) begin
               if (sem_count[id] != 16'hFFFF) sem_count[id] = sem_count[id] + 16'd1;
            end else begin
               post(1'b1, sem_ring[id][sem_head[id]], semtq_pkg::ST_OK, 8'd0, 1'b0);
               sem_head[id] = (sem_head[id] + 1) % MAX_WAIT;
               sem_waiters[id]--;
            end
            post(1'b0, r.requester, semtq_pkg::ST_OK, 8'd0, 1'b1);
         end
      endcase
   endfunction

   function automatic int lowest_free();
      int s;
      int slot;
      slot = -1;
      for (s = NUM_SEM - 1; s >= 0; s--)
         if (!sem_live[s]) slot = s;
      return slot;
   endfunction

   function automatic int pick_live();
      int cands [$];
      for (int s = 0; s < NUM_SEM; s++)
         if (sem_live[s]) cands.push_back(s);
      if (cands.size() == 0) return -1;
      return cands[$urandom_range(0, cands.size() - 1)];
   endfunction

   // Sends one request item; valid stays high after acceptance so that
   // back-to-back items need no gap.
   task automatic issue_op(semtq_pkg::kind_type k, logic [7:0] idx, logic [15:0] initv,
                           logic [14:0] who);
      semtq_pkg::req_type r;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      r.kind       = k;
      r.sem_index  = idx;
      r.init_value = initv;
      r.requester  = who;
      req_valid <= 1'b1;
      req_item  <= r;
      do @(posedge clock); while (req_stall);
      run_semaphore_op(r);
      burst_left--;
   endtask

   // Holds off new requests until every owed item has come back.
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (due_notices.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic test_directed();
      int a;
      int b;
      issue_op(semtq_pkg::KIND_DESTROY, 8'd0, 16'hFFFF, 15'h7FFF);   // free slot
      issue_op(semtq_pkg::KIND_WAIT, 8'd63, 16'd0, 15'd0);
      issue_op(semtq_pkg::KIND_SIGNAL, 8'd255, 16'd0, 15'h2AAA);     // id out of range
      a = lowest_free();
      issue_op(semtq_pkg::KIND_CREATE, 8'd255, 16'd0, 15'd0);
      b = lowest_free();
      issue_op(semtq_pkg::KIND_CREATE, 8'd0, 16'hFFFF, 15'h7FFF);
      issue_op(semtq_pkg::KIND_SIGNAL, 8'(b), 16'h5555, 15'h1111);   // count saturates
      issue_op(semtq_pkg::KIND_WAIT, 8'(b), 16'hAAAA, 15'h2222);
      issue_op(semtq_pkg::KIND_WAIT, 8'(a), 16'd0, 15'h7FFF);        // blocks
      issue_op(semtq_pkg::KIND_WAIT, 8'(a), 16'd0, 15'd0);
      issue_op(semtq_pkg::KIND_WAIT, 8'(a), 16'd0, 15'h1234);
      issue_op(semtq_pkg::KIND_SIGNAL, 8'(a), 16'd0, 15'h5555);      // wakes oldest
      issue_op(semtq_pkg::KIND_DESTROY, 8'(a), 16'd0, 15'h0F0F);     // wakes the rest
      issue_op(semtq_pkg::KIND_WAIT, 8'(a), 16'd0, 15'h3333);        // freed slot
      issue_op(semtq_pkg::KIND_SIGNAL, 8'd64, 16'd0, 15'h4444);
      issue_op(semtq_pkg::KIND_CREATE, 8'd7, 16'd1, 15'h0001);       // reuses lowest slot
      issue_op(semtq_pkg::KIND_WAIT, 8'(a), 16'd0, 15'h0002);
      issue_op(semtq_pkg::KIND_WAIT, 8'(a), 16'd0, 15'h0004);
      issue_op(semtq_pkg::KIND_DESTROY, 8'(b), 16'd0, 15'h0008);
      issue_op(semtq_pkg::KIND_DESTROY, 8'(a), 16'd0, 15'h0010);
      issue_op(semtq_pkg::KIND_DESTROY, 8'(a), 16'd0, 15'h0020);     // already freed
   endtask

   task automatic test_table_full();
      int s;
      while (lowest_free() >= 0)
         issue_op(semtq_pkg::KIND_CREATE, 8'($urandom), 16'($urandom), 15'($urandom));
      repeat (2)
         issue_op(semtq_pkg::KIND_CREATE, 8'($urandom), 16'($urandom), 15'($urandom));
      s = $urandom_range(1, NUM_SEM - 1);
      issue_op(semtq_pkg::KIND_DESTROY, 8'(s), 16'($urandom), 15'($urandom));
      issue_op(semtq_pkg::KIND_CREATE, 8'($urandom), 16'd0, 15'($urandom));
      for (s = NUM_SEM - 1; s >= 0; s--)
         if (sem_live[s])
            issue_op(semtq_pkg::KIND_DESTROY, 8'(s), 16'($urandom), 15'($urandom));
   endtask

   task automatic test_queue_full();
      int s;
      s = lowest_free();
      issue_op(semtq_pkg::KIND_CREATE, 8'($urandom), 16'd0, 15'($urandom));
      // one more than the ring holds: the last one is refused
      repeat (MAX_WAIT + 1)
         issue_op(semtq_pkg::KIND_WAIT, 8'(s), 16'($urandom), 15'($urandom));
      issue_op(semtq_pkg::KIND_SIGNAL, 8'(s), 16'($urandom), 15'($urandom));
      repeat (2) issue_op(semtq_pkg::KIND_WAIT, 8'(s), 16'($urandom), 15'($urandom));
      issue_op(semtq_pkg::KIND_DESTROY, 8'(s), 16'($urandom), 15'($urandom));
   endtask

   task automatic test_random_mix(int n);
      int i;
      int roll;
      int s;
      int live;
      logic [15:0] initv;
      for (i = 0; i < n; i++) begin
         roll = $urandom_range(0, 99);
         live = 0;
         for (s = 0; s < NUM_SEM; s++) live += sem_live[s];
         if (roll < 8) begin
            issue_op(semtq_pkg::kind_type'($urandom_range(0, 3)), 8'($urandom),
                     16'($urandom), 15'($urandom));
         end else if (live == 0 || (roll < 25 && live < 60)) begin
            roll = $urandom_range(0, 9);
            if (roll < 5)      initv = 16'd0;
            else if (roll < 8) initv = 16'($urandom_range(1, 3));
            else if (roll < 9) initv = 16'($urandom_range(65534, 65535));
            else               initv = 16'($urandom);
            issue_op(semtq_pkg::KIND_CREATE, 8'($urandom), initv, 15'($urandom));
         end else begin
            s = pick_live();
            roll = $urandom_range(0, 99);
            if (roll < 10)
               issue_op(semtq_pkg::KIND_DESTROY, 8'(s), 16'($urandom), 15'($urandom));
            else if (roll < 55)
               issue_op(semtq_pkg::KIND_WAIT, 8'(s), 16'($urandom), 15'($urandom));
            else
               issue_op(semtq_pkg::KIND_SIGNAL, 8'(s), 16'($urandom), 15'($urandom));
         end
         if ($urandom_range(0, 59) == 0) settle();
      end
   endtask

   // receiver stall pattern: modes of random length
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 200);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 9) < 7);
         default: rsp_stall <= stall_left[0];
      endcase
   end

   always @(posedge clock) begin
      semtq_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_notices.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected item: wake=%0b target=%h status=%0d created=%0d last=%0b",
                        rsp_item.is_wake, rsp_item.target_process, rsp_item.status,
                        rsp_item.created_index, rsp_item.last);
            mismatch_count++;
         end else begin
            want = due_notices.pop_front();
            if (rsp_item.is_wake !== want.is_wake ||
                rsp_item.target_process !== want.target_process ||
                rsp_item.status !== want.status ||
                rsp_item.created_index !== want.created_index ||
                rsp_item.last !== want.last) begin
               if (mismatch_count < 10)
                  $display({"mismatch: expected wake=%0b target=%h status=%0d created=%0d ",
                            "last=%0b, got wake=%0b target=%h status=%0d created=%0d last=%0b"},
                           want.is_wake, want.target_process, want.status,
                           want.created_index, want.last,
                           rsp_item.is_wake, rsp_item.target_process, rsp_item.status,
                           rsp_item.created_index, rsp_item.last);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_item  <= '0;
      rsp_stall <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      settle();
      test_table_full();
      settle();
      test_queue_full();
      settle();
      test_random_mix(320);
      settle();
      repeat (80) @(posedge clock);
      if (mismatch_count == 0 && due_notices.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
